// ===== hw/rtl/dedup_sorted_index_set_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the sorted index set
// Concurrent checks on one clock with a synchronous active-low reset.
// ----------------------------------------------------------------------------
`ifndef DEDUP_SORTED_INDEX_SET_ASSERT_SVH
`define DEDUP_SORTED_INDEX_SET_ASSERT_SVH
`ifndef SYNTH
`define DSIS_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("dsis assertion failed");
`define DSIS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dsis assertion failed");
`else
`define DSIS_ASSERT(label, clk, rst_n, prop)
`define DSIS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== hw/rtl/dsis_pkg.sv =====
// ----------------------------------------------------------------------------
// dsis_pkg
// Types and constants shared by the sorted index set and its cells.
// ----------------------------------------------------------------------------
`default_nettype none
package dsis_pkg;

    localparam int DSIS_CAPACITY = 32;
    localparam int KEY_W         = 32;
    localparam int CNT_OUT_W     = 6;
    localparam int STATUS_W      = 3;
    localparam int OUT_DATA_W    = 40;  // key + count, padded to bytes

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_READ   = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STAT_INSERTED = 3'd0,
        STAT_DUP      = 3'd1,
        STAT_FULL     = 3'd2,
        STAT_ITEM     = 3'd3,
        STAT_EMPTY    = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_INSERT,
        ST_READ
    } t_state;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_ROTATE
    } t_cell_op;

    // broadcast from the controller to every cell
    typedef struct packed {
        t_cell_op                 op;
        logic signed [KEY_W-1:0]  key;
    } t_cell_ctl;

    // what a cell shows its neighbors and the controller
    typedef struct packed {
        logic                     valid;
        logic                     gt;    // empty, or stored key above broadcast key
        logic                     eq;
        logic signed [KEY_W-1:0]  key;
    } t_cell_link;

endpackage
`default_nettype wire

// ===== hw/rtl/dsis_cell.sv =====
// ----------------------------------------------------------------------------
// dsis_cell
// One slot of the sorted chain: compares against the broadcast key, shifts
// up on insert, rotates down on read.
// ----------------------------------------------------------------------------
`default_nettype none
module dsis_cell (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  dsis_pkg::t_cell_ctl        i_ctl,
    input  dsis_pkg::t_cell_link       i_left,
    input  dsis_pkg::t_cell_link       i_right,
    input  wire [dsis_pkg::KEY_W-1:0]  i_wrap_key,
    output dsis_pkg::t_cell_link       o_link
);
    import dsis_pkg::*;

    logic                    r_valid;
    logic signed [KEY_W-1:0] r_key;
    logic                    n_valid;
    logic signed [KEY_W-1:0] n_key;
    logic                    w_gt;

    assign w_gt = !r_valid || (r_key > $signed(i_ctl.key));

    always_comb begin
        n_valid = r_valid;
        n_key   = r_key;
        case (i_ctl.op)
            CELL_INSERT: begin
                // left neighbor is also above the key: take its key, else the new one
                if (w_gt) begin
                    n_key = i_left.gt ? i_left.key : i_ctl.key;
                end
                n_valid = r_valid || i_left.valid;
            end
            CELL_ROTATE: begin
                n_key = i_right.valid ? i_right.key : $signed(i_wrap_key);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_key <= n_key;
    end

    assign o_link.valid = r_valid;
    assign o_link.gt    = w_gt;
    assign o_link.eq    = r_valid && (r_key == i_ctl.key);
    assign o_link.key   = r_key;

endmodule
`default_nettype wire

// ===== hw/rtl/dedup_sorted_index_set.sv =====
// ----------------------------------------------------------------------------
// dedup_sorted_index_set
// Sorted set of signed keys with duplicate rejection, held in a cell chain.
// ----------------------------------------------------------------------------
// The set lives in a row of CAPACITY cells kept in ascending order, filled
// from cell 0. An insert takes the word, then the key is broadcast to all
// cells, compared in parallel, and on a new key the cells above it shift up
// by one in the same cycle; one result word with status inserted, duplicate
// or full. A read takes the word, then the chain rotates toward cell 0 once
// per cycle and holds while the output is stalled, and cell 0 feeds one
// sorted key per result word, so after count steps the set is back in place.
// One command is in flight at a time; the next word is taken once the last
// result word of the current one is registered.
// ----------------------------------------------------------------------------
`default_nettype none
module dedup_sorted_index_set #(
    parameter int CAPACITY = dsis_pkg::DSIS_CAPACITY
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_s_tvalid,
    output logic                             o_s_tready,
    input  wire [dsis_pkg::KEY_W-1:0]        i_s_tdata,   // [31:0] key_in
    input  wire [0:0]                        i_s_tuser,   // [0] command
    output logic                             o_m_tvalid,
    input  wire                              i_m_tready,
    output logic [dsis_pkg::OUT_DATA_W-1:0]  o_m_tdata,   // [31:0] key_out, [37:32] count_out
    output logic [dsis_pkg::STATUS_W-1:0]    o_m_tuser,   // [2:0] status
    output logic                             o_m_tlast
);
    import dsis_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);

    t_state                  r_state;
    t_state                  n_state;
    logic signed [KEY_W-1:0] r_key;
    logic [CW-1:0]           r_count;
    logic [CW-1:0]           r_remain;

    logic                    r_out_valid;
    t_status                 r_out_status;
    logic [KEY_W-1:0]        r_out_key;
    logic [CNT_OUT_W-1:0]    r_out_count;
    logic                    r_out_last;

    t_cell_ctl               w_ctl;
    t_cell_link              w_link  [CAPACITY];
    t_cell_link              w_left  [CAPACITY];
    t_cell_link              w_right [CAPACITY];
    logic [CAPACITY-1:0]     w_eq_vec;
    logic [CAPACITY-1:0]     w_valid_vec;
    logic                    w_dup;
    logic                    w_full;
    logic                    w_slot;
    logic                    w_accept;

    // output controls
    logic                    w_load;
    t_status                 w_status;
    logic [KEY_W-1:0]        w_okey;
    logic [CW-1:0]           w_ocount;
    logic                    w_olast;
    t_cell_op                w_op;
    logic [CW-1:0]           n_count;
    logic [CW-1:0]           n_remain;

    // ---------------- cell chain ----------------
    assign w_ctl.op  = w_op;
    assign w_ctl.key = r_key;

    for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
        if (gi == 0) begin : g_first
            assign w_left[gi] = '{valid: 1'b1, gt: 1'b0, eq: 1'b0, key: '0};
        end else begin : g_mid
            assign w_left[gi] = w_link[gi-1];
        end
        if (gi == CAPACITY - 1) begin : g_end
            assign w_right[gi] = '{valid: 1'b0, gt: 1'b0, eq: 1'b0, key: '0};
        end else begin : g_inner
            assign w_right[gi] = w_link[gi+1];
        end

        dsis_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_ctl),
            .i_left     (w_left[gi]),
            .i_right    (w_right[gi]),
            .i_wrap_key (w_link[0].key),
            .o_link     (w_link[gi])
        );

        assign w_eq_vec[gi]    = w_link[gi].eq;
        assign w_valid_vec[gi] = w_link[gi].valid;
    end

    assign w_dup    = |w_eq_vec;
    assign w_full   = (r_count == CW'(CAPACITY));
    assign w_slot   = !r_out_valid || i_m_tready;
    assign w_accept = i_s_tvalid && o_s_tready;

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = (i_s_tuser[0] == CMD_READ) ? ST_READ : ST_INSERT;
                end
            end
            ST_INSERT: begin
                if (w_slot) begin
                    n_state = ST_IDLE;
                end
            end
            ST_READ: begin
                if (w_slot && (r_remain <= CW'(1))) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // ---------------- outputs of the controller ----------------
    always_comb begin
        o_s_tready = 1'b0;
        w_load     = 1'b0;
        w_status   = STAT_INSERTED;
        w_okey     = '0;
        w_ocount   = r_count;
        w_olast    = 1'b1;
        w_op       = CELL_HOLD;
        n_count    = r_count;
        n_remain   = r_remain;
        unique case (r_state)
            ST_IDLE: begin
                o_s_tready = 1'b1;
                n_remain   = r_count;
            end
            ST_INSERT: begin
                if (w_slot) begin
                    w_load = 1'b1;
                    if (w_dup) begin
                        w_status = STAT_DUP;
                    end else if (w_full) begin
                        w_status = STAT_FULL;
                    end else begin
                        w_status = STAT_INSERTED;
                        w_op     = CELL_INSERT;
                        n_count  = r_count + CW'(1);
                        w_ocount = n_count;
                    end
                end
            end
            ST_READ: begin
                if (w_slot) begin
                    w_load = 1'b1;
                    if (r_count == '0) begin
                        w_status = STAT_EMPTY;
                    end else begin
                        w_status = STAT_ITEM;
                        w_okey   = w_link[0].key;
                        w_olast  = (r_remain == CW'(1));
                        w_op     = CELL_ROTATE;
                        n_remain = r_remain - CW'(1);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_remain    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_remain <= n_remain;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (w_accept) begin
            r_key <= $signed(i_s_tdata);
        end
        if (w_load) begin
            r_out_status <= w_status;
            r_out_key    <= w_okey;
            r_out_count  <= CNT_OUT_W'(w_ocount);
            r_out_last   <= w_olast;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(OUT_DATA_W - KEY_W - CNT_OUT_W){1'b0}}, r_out_count, r_out_key};
    assign o_m_tuser  = r_out_status;
    assign o_m_tlast  = r_out_last;

    // ---------------- checks ----------------
`include "dedup_sorted_index_set_assert.svh"
    `DSIS_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CW'(CAPACITY))
    `DSIS_ASSERT(a_valid_matches_count, i_clk, i_rst_n, $countones(w_valid_vec) == r_count)
    `DSIS_ASSERT_NEXT(a_insert_grows, i_clk, i_rst_n, w_load && (w_status == STAT_INSERTED), r_count == $past(r_count) + CW'(1))
    `DSIS_ASSERT_NEXT(a_read_keeps_count, i_clk, i_rst_n, r_state == ST_READ, r_count == $past(r_count))

endmodule
`default_nettype wire

// ===== bench/tb_dedup_sorted_index_set.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dedup_sorted_index_set
// Self-checking bench for the sorted index set: insert and read commands go in
// on the input stream, and a scoreboard predicts every status, sorted key,
// count and last flag. Random idle and stall bursts hit both stream sides.
// ----------------------------------------------------------------------------
module tb_dedup_sorted_index_set;
    import dsis_pkg::*;

    localparam int RANDOM_ITEMS  = 330;
    localparam int QUIET_LIMIT   = 4000;   // cycles with no word moving on either side
    localparam int DRAIN_CYCLES  = 20;

    typedef struct {
        t_status               status;
        logic [KEY_W-1:0]      key;
        logic [CNT_OUT_W-1:0]  count;
        logic                  last;
    } t_set_result;

    class index_set_scoreboard;
        logic signed [KEY_W-1:0] sorted_keys[$];
        t_set_result             pending_results[$];
        int                      errors;
        int                      words_checked;
        int                      status_tally[5];

        function new();
            errors = 0;
            words_checked = 0;
            foreach (status_tally[i]) status_tally[i] = 0;
        endfunction

        function void note_command(logic cmd, logic [KEY_W-1:0] key);
            t_set_result             r;
            logic signed [KEY_W-1:0] key_s;
            int                      pos;
            bit                      found;
            key_s = key;
            found = 0;
            pos = 0;
            if (cmd == CMD_INSERT) begin
                foreach (sorted_keys[i]) begin
                    if (sorted_keys[i] == key_s) found = 1;
                end
                if (found) begin
                    r.status = STAT_DUP;
                end else if (sorted_keys.size() >= DSIS_CAPACITY) begin
                    r.status = STAT_FULL;
                end else begin
                    while (pos < sorted_keys.size() && sorted_keys[pos] < key_s) pos++;
                    sorted_keys.insert(pos, key_s);
                    r.status = STAT_INSERTED;
                end
                r.key = '0;
                r.count = CNT_OUT_W'(sorted_keys.size());
                r.last = 1'b1;
                pending_results.push_back(r);
            end else if (sorted_keys.size() == 0) begin
                r.status = STAT_EMPTY;
                r.key = '0;
                r.count = '0;
                r.last = 1'b1;
                pending_results.push_back(r);
            end else begin
                foreach (sorted_keys[i]) begin
                    r.status = STAT_ITEM;
                    r.key = sorted_keys[i];
                    r.count = CNT_OUT_W'(sorted_keys.size());
                    r.last = (i == sorted_keys.size() - 1);
                    pending_results.push_back(r);
                end
            end
        endfunction

        task flag_mismatch(string what);
            errors++;
            $display("[%0t] mismatch: %s", $time, what);
        endtask

        task check_result(logic [STATUS_W-1:0] st, logic [OUT_DATA_W-1:0] data, logic last);
            t_set_result want;
            words_checked++;
            if (pending_results.size() == 0) begin
                flag_mismatch($sformatf("unexpected word status=%0d key=%0d count=%0d",
                                        st, $signed(data[KEY_W-1:0]), data[37:32]));
                return;
            end
            want = pending_results.pop_front();
            status_tally[want.status]++;
            if (st !== want.status)
                flag_mismatch($sformatf("status %0d, want %s", st, want.status.name()));
            if (data[KEY_W-1:0] !== want.key)
                flag_mismatch($sformatf("key %0d, want %0d",
                                        $signed(data[KEY_W-1:0]), $signed(want.key)));
            if (data[37:32] !== want.count)
                flag_mismatch($sformatf("count %0d, want %0d", data[37:32], want.count));
            if (data[OUT_DATA_W-1:38] !== '0)
                flag_mismatch($sformatf("pad bits %b not zero", data[OUT_DATA_W-1:38]));
            if (last !== want.last)
                flag_mismatch($sformatf("last %b, want %b", last, want.last));
        endtask
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_s_tvalid = 1'b0;
    logic                   o_s_tready;
    logic [KEY_W-1:0]       i_s_tdata = '0;     // [31:0] key_in
    logic [0:0]             i_s_tuser = '0;     // [0] command
    logic                   o_m_tvalid;
    logic                   i_m_tready = 1'b1;
    logic [OUT_DATA_W-1:0]  o_m_tdata;          // [31:0] key_out, [37:32] count_out
    logic [STATUS_W-1:0]    o_m_tuser;          // [2:0] status
    logic                   o_m_tlast;

    index_set_scoreboard    sb;
    logic [KEY_W-1:0]       tried_keys[$];
    bit                     idle_on = 1'b1;
    int                     n_reads = 0;
    int                     n_inserts = 0;

    dedup_sorted_index_set dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Returns in the step of the edge that took the word; valid stays up unless a gap follows.
    task automatic send_word(logic cmd, logic [KEY_W-1:0] key);
        int gap;
        gap = 0;
        if (idle_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 11);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= cmd;
        i_s_tdata  <= key;
        do @(posedge i_clk); while (!(i_s_tvalid && o_s_tready === 1'b1));
        sb.note_command(cmd, key);
        if (cmd == CMD_INSERT) begin
            tried_keys.push_back(key);
            n_inserts++;
        end else begin
            n_reads++;
        end
    endtask

    // result side: check taken words, then pick tready for the next cycle
    initial begin : result_sink
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_tvalid === 1'b1 && i_m_tready)
                sb.check_result(o_m_tuser, o_m_tdata, o_m_tlast);
            if (stall_left > 0) begin
                stall_left--;
                if (stall_left == 0) i_m_tready <= 1'b1;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 11);
                i_m_tready <= 1'b0;
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        forever begin
            @(posedge i_clk);
            if ((i_s_tvalid && o_s_tready === 1'b1) || (o_m_tvalid === 1'b1 && i_m_tready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= QUIET_LIMIT) begin
                $display("[%0t] watchdog: no word moved for %0d cycles", $time, QUIET_LIMIT);
                $display("status: fail");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int               roll;
        int               new_pct;
        logic [KEY_W-1:0] k;
        sb = new();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty read, extreme keys, alternating bits, duplicates at the ends
        send_word(CMD_READ,   32'h1234_5678);
        send_word(CMD_INSERT, 32'h8000_0000);
        send_word(CMD_INSERT, 32'h7fff_ffff);
        send_word(CMD_INSERT, 32'h0000_0000);
        send_word(CMD_INSERT, 32'hffff_ffff);
        send_word(CMD_INSERT, 32'h0000_0001);
        send_word(CMD_INSERT, 32'h5555_5555);
        send_word(CMD_INSERT, 32'haaaa_aaaa);
        send_word(CMD_INSERT, 32'h8000_0000);
        send_word(CMD_INSERT, 32'h7fff_ffff);
        send_word(CMD_INSERT, 32'h0000_0000);
        send_word(CMD_READ,   32'hffff_ffff);
        send_word(CMD_INSERT, 32'h8000_0001);
        send_word(CMD_INSERT, 32'h7fff_fffe);
        send_word(CMD_READ,   32'h0000_0000);

        // random: slow fill first so reads see many set sizes, then run into the full set
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS - 40) idle_on = 1'b0;
            roll = $urandom_range(0, 99);
            new_pct = (n < 150) ? 12 : 45;
            if (roll < 18) begin
                send_word(CMD_READ, $urandom());
            end else if (roll < 18 + new_pct) begin
                roll = $urandom_range(0, 99);
                if (roll < 60)
                    k = $urandom();
                else if (roll < 85)
                    k = tried_keys[$urandom_range(0, tried_keys.size() - 1)]
                        + (($urandom_range(0, 1) == 0) ? 32'd1 : 32'hffff_ffff);
                else
                    case ($urandom_range(0, 3))
                        0: k = 32'h8000_0000;
                        1: k = 32'h7fff_ffff;
                        2: k = 32'h0000_0000;
                        default: k = 32'hffff_ffff;
                    endcase
                send_word(CMD_INSERT, k);
            end else begin
                send_word(CMD_INSERT, tried_keys[$urandom_range(0, tried_keys.size() - 1)]);
            end
        end
        i_s_tvalid <= 1'b0;

        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d commands (%0d inserts, %0d reads), %0d result words, %0d keys held",
                 n_inserts + n_reads, n_inserts, n_reads, sb.words_checked,
                 sb.sorted_keys.size());
        $display("outcomes: inserted %0d, duplicate %0d, full %0d, listed %0d, empty %0d",
                 sb.status_tally[STAT_INSERTED], sb.status_tally[STAT_DUP],
                 sb.status_tally[STAT_FULL], sb.status_tally[STAT_ITEM],
                 sb.status_tally[STAT_EMPTY]);
        if (sb.errors == 0) begin
            $display("status: pass");
        end else begin
            $display("%0d mismatches", sb.errors);
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/dsis_pkg.sv
hw/rtl/dsis_cell.sv
hw/rtl/dedup_sorted_index_set.sv
bench/tb_dedup_sorted_index_set.sv
